// ===== hdl/spatial_hilbert_key_core_macros.svh =====
// Assertion helpers for the assertion checker (hdl/shk_checker.sv) of this block.
// Every macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef SPATIAL_HILBERT_KEY_CORE_MACROS_SVH
`define SPATIAL_HILBERT_KEY_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHK_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spatial hilbert key check failed");

// The consequent must hold from the cycle after the antecedent.
`define SHK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spatial hilbert key check failed");

`endif

// ===== hdl/shk_pkg.sv =====
package shk_pkg;

    // Atoms with an index at or above this bound produce no key.
    localparam int unsigned MAX_ATOMS = 1048576;

    localparam int KEY_W   = 30;
    localparam int CELL_W  = 10;
    localparam int DIGITS  = KEY_W / 3;
    localparam int FRAC_W  = 56;
    localparam int TERM_W  = 57;
    localparam int APB_ADDR_W = 5;

    // Pipeline depth from an accepted start to the done strobe.
    localparam int PIPE_DEPTH = 11 + DIGITS;

    localparam logic [31:0] INV_RESET = 32'h0100_0000;

    localparam logic [31:0] SPREAD_M16 = 32'h0300_00FF;
    localparam logic [31:0] SPREAD_M8  = 32'h0300_F00F;
    localparam logic [31:0] SPREAD_M4  = 32'h030C_30C3;
    localparam logic [31:0] SPREAD_M2  = 32'h0924_9249;
    localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((32'h3FFF_FFFF / 7) >> 1);

    typedef enum logic [2:0] {
        REG_INV_X_LEN = 3'd0,
        REG_INV_Y_LEN = 3'd1,
        REG_INV_Z_LEN = 3'd2,
        REG_BOX_B_X   = 3'd3,
        REG_BOX_C_X   = 3'd4,
        REG_BOX_C_Y   = 3'd5
    } reg_idx_t;

    // State handed from one Hilbert digit cell to the next.
    typedef struct packed {
        logic [KEY_W-1:0] code;
        logic [KEY_W-1:0] acc;
        logic [1:0]       rot;
        logic [2:0]       flip;
    } hcell_t;

    // Places the ten bits of v at every third bit position.
    function automatic logic [KEY_W-1:0] spread3(input logic [CELL_W-1:0] v);
        logic [31:0] s;
        s = 32'(v);
        s = (s | (s << 16)) & SPREAD_M16;
        s = (s | (s << 8))  & SPREAD_M8;
        s = (s | (s << 4))  & SPREAD_M4;
        s = (s | (s << 2))  & SPREAD_M2;
        return s[KEY_W-1:0];
    endfunction

    // Prefix XOR from the top bit down, the last step of the Hilbert map.
    function automatic logic [KEY_W-1:0] gray_decode(input logic [KEY_W-1:0] a);
        logic [KEY_W-1:0] r;
        r = a;
        r = r ^ (r >> 1);
        r = r ^ (r >> 2);
        r = r ^ (r >> 4);
        r = r ^ (r >> 8);
        r = r ^ (r >> 16);
        return r;
    endfunction

    // Clamps a wide signed value to the signed 32-bit range.
    function automatic logic [31:0] sat32(input logic [58:0] v);
        logic [27:0] top;
        top = v[58:31];
        if (top == '0 || top == '1) begin
            return v[31:0];
        end
        return v[58] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

endpackage

// ===== hdl/spatial_hilbert_key_core.sv =====
// Hilbert sort key for one atom in a triclinic periodic box.
//
// An atom enters as pos_x, pos_y, pos_z (signed Q16.16) and atom_index with a
// one-cycle start pulse. busy never rises, so a transfer is accepted on every
// cycle that start is high and a new atom may follow in the very next cycle.
// Each key comes out on hilbert_key with atom_tag for exactly one cycle,
// marked by done, at the end of the pipeline. The sustained rate is one atom
// per cycle: every multiply, correction and Hilbert digit owns its own stage.
// The receiver cannot hold results off, and nothing here ever needs to stall.
//
// The box is set over the APB port: six 32-bit registers at byte addresses
// 0x00 to 0x14 (three reciprocal lengths in Q8.24, three off-diagonal box
// components in Q16.16). pready is always high and writes are meant to happen
// only while no atom is in flight. Reset clears the pipeline valid bits and
// loads reciprocals of 1.0 and off-diagonals of zero; no clearing pass runs,
// so a start is accepted in the first cycle after reset is released.
module spatial_hilbert_key_core (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          start,
    output logic                          busy,
    input  logic [31:0]                   pos_x,
    input  logic [31:0]                   pos_y,
    input  logic [31:0]                   pos_z,
    input  logic [19:0]                   atom_index,

    output logic                          done,
    output logic [29:0]                   hilbert_key,
    output logic [19:0]                   atom_tag,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [shk_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int DEPTH  = shk_pkg::PIPE_DEPTH;
    localparam int DIGITS = shk_pkg::DIGITS;

    // Configuration registers.
    logic [31:0] inv_x_len_reg;
    logic [31:0] inv_y_len_reg;
    logic [31:0] inv_z_len_reg;
    logic [31:0] box_b_x_reg;
    logic [31:0] box_c_x_reg;
    logic [31:0] box_c_y_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            inv_x_len_reg <= shk_pkg::INV_RESET;
            inv_y_len_reg <= shk_pkg::INV_RESET;
            inv_z_len_reg <= shk_pkg::INV_RESET;
            box_b_x_reg   <= '0;
            box_c_x_reg   <= '0;
            box_c_y_reg   <= '0;
        end
        else if (cfg_write) begin
            case (paddr[4:2])
                shk_pkg::REG_INV_X_LEN: inv_x_len_reg <= pwdata;
                shk_pkg::REG_INV_Y_LEN: inv_y_len_reg <= pwdata;
                shk_pkg::REG_INV_Z_LEN: inv_z_len_reg <= pwdata;
                shk_pkg::REG_BOX_B_X:   box_b_x_reg   <= pwdata;
                shk_pkg::REG_BOX_C_X:   box_c_x_reg   <= pwdata;
                shk_pkg::REG_BOX_C_Y:   box_c_y_reg   <= pwdata;
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            shk_pkg::REG_INV_X_LEN: prdata = inv_x_len_reg;
            shk_pkg::REG_INV_Y_LEN: prdata = inv_y_len_reg;
            shk_pkg::REG_INV_Z_LEN: prdata = inv_z_len_reg;
            shk_pkg::REG_BOX_B_X:   prdata = box_b_x_reg;
            shk_pkg::REG_BOX_C_X:   prdata = box_c_x_reg;
            shk_pkg::REG_BOX_C_Y:   prdata = box_c_y_reg;
            default:                prdata = '0;
        endcase
    end

    // Every stage moves on each cycle, so the block is never busy. Out-of-range
    // atoms travel as bubbles: their valid bit simply never gets set.
    assign busy = 1'b0;

    logic             take;
    logic [DEPTH-1:0] valid_reg;

    assign take = start && !busy && (32'(atom_index) < shk_pkg::MAX_ATOMS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else begin
            valid_reg <= {valid_reg[DEPTH-2:0], take};
        end
    end

    // Side data delay lines, each tapped where its stage needs it.
    logic [31:0] py_pipe_reg [0:2];
    logic [31:0] px_pipe_reg [0:6];
    logic [19:0] tag_pipe_reg [0:DEPTH-1];
    logic [shk_pkg::TERM_W-1:0] zx_pipe_reg [0:3];
    logic [shk_pkg::CELL_W-1:0] cz_pipe_reg [0:7];
    logic [shk_pkg::CELL_W-1:0] cy_pipe_reg [0:3];

    // z axis: the fraction is the scaled position itself.
    logic signed [shk_pkg::FRAC_W-1:0] frac_z;
    logic [shk_pkg::TERM_W-1:0]        term_zy;
    logic [shk_pkg::TERM_W-1:0]        term_zx;

    shk_scale u_scale_z (
        .clk     (clk),
        .pos     ($signed(pos_z)),
        .inv_len (inv_z_len_reg),
        .frac    (frac_z)
    );

    shk_offdiag u_offdiag_zy (
        .clk  (clk),
        .frac (frac_z),
        .coef ($signed(box_c_y_reg)),
        .term (term_zy)
    );

    shk_offdiag u_offdiag_zx (
        .clk  (clk),
        .frac (frac_z),
        .coef ($signed(box_c_x_reg)),
        .term (term_zx)
    );

    // y axis: remove the c vector's share, saturate, then scale.
    logic [31:0] dy_next;
    logic [31:0] dy_reg;
    logic signed [shk_pkg::FRAC_W-1:0] frac_y;
    logic [shk_pkg::TERM_W-1:0]        term_yx;

    always_comb
    begin
        dy_next = shk_pkg::sat32({{27{py_pipe_reg[2][31]}}, py_pipe_reg[2]}
                               - {{2{term_zy[56]}}, term_zy});
    end

    shk_scale u_scale_y (
        .clk     (clk),
        .pos     ($signed(dy_reg)),
        .inv_len (inv_y_len_reg),
        .frac    (frac_y)
    );

    shk_offdiag u_offdiag_yx (
        .clk  (clk),
        .frac (frac_y),
        .coef ($signed(box_b_x_reg)),
        .term (term_yx)
    );

    // x axis: remove the shares of both b and c, saturate, then scale.
    logic [31:0] dx_next;
    logic [31:0] dx_reg;
    logic signed [shk_pkg::FRAC_W-1:0] frac_x;

    always_comb
    begin
        dx_next = shk_pkg::sat32({{27{px_pipe_reg[6][31]}}, px_pipe_reg[6]}
                               - {{2{term_yx[56]}}, term_yx}
                               - {{2{zx_pipe_reg[3][56]}}, zx_pipe_reg[3]});
    end

    shk_scale u_scale_x (
        .clk     (clk),
        .pos     ($signed(dx_reg)),
        .inv_len (inv_x_len_reg),
        .frac    (frac_x)
    );

    // The wrapped fraction is the low 32 bits of each fraction; its top ten
    // bits are the cell coordinate. The three are interleaved x, y, z from
    // bit 0 and pre-XORed for the digit chain.
    logic [shk_pkg::KEY_W-1:0] morton;
    shk_pkg::hcell_t           seed_next;
    shk_pkg::hcell_t           seed_reg;

    always_comb
    begin
        morton = shk_pkg::spread3(frac_x[31:22])
               | (shk_pkg::spread3(cy_pipe_reg[3]) << 1)
               | (shk_pkg::spread3(cz_pipe_reg[7]) << 2);
        seed_next.code = morton ^ (morton >> 3);
        seed_next.acc  = '0;
        seed_next.rot  = 2'd0;
        seed_next.flip = 3'd0;
    end

    always_ff @(posedge clk)
    begin
        py_pipe_reg[0]  <= pos_y;
        px_pipe_reg[0]  <= pos_x;
        tag_pipe_reg[0] <= atom_index;
        zx_pipe_reg[0]  <= term_zx;
        cz_pipe_reg[0]  <= frac_z[31:22];
        cy_pipe_reg[0]  <= frac_y[31:22];
        for (int i = 1; i < 3; i++) begin
            py_pipe_reg[i] <= py_pipe_reg[i-1];
        end
        for (int i = 1; i < 7; i++) begin
            px_pipe_reg[i] <= px_pipe_reg[i-1];
        end
        for (int i = 1; i < DEPTH; i++) begin
            tag_pipe_reg[i] <= tag_pipe_reg[i-1];
        end
        for (int i = 1; i < 4; i++) begin
            zx_pipe_reg[i] <= zx_pipe_reg[i-1];
            cy_pipe_reg[i] <= cy_pipe_reg[i-1];
        end
        for (int i = 1; i < 8; i++) begin
            cz_pipe_reg[i] <= cz_pipe_reg[i-1];
        end
        dy_reg   <= dy_next;
        dx_reg   <= dx_next;
        seed_reg <= seed_next;
    end

    // Ten digit cells, most significant digit first; each hands its
    // rotation and flip state to the next one every cycle.
    shk_pkg::hcell_t chain [0:DIGITS];

    assign chain[0] = seed_reg;

    for (genvar k = 0; k < DIGITS; k++) begin : g_digit
        shk_hcell u_hcell (
            .clk       (clk),
            .state_in  (chain[k]),
            .state_out (chain[k+1])
        );
    end

    logic [shk_pkg::KEY_W-1:0] key_next;
    logic [shk_pkg::KEY_W-1:0] key_reg;

    always_comb
    begin
        key_next = shk_pkg::gray_decode(chain[DIGITS].acc ^ shk_pkg::KEY_MASK);
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign done        = valid_reg[DEPTH-1];
    assign hilbert_key = key_reg;
    assign atom_tag    = tag_pipe_reg[DEPTH-1];

endmodule

// ===== hdl/shk_scale.sv =====
module shk_scale (
    input  logic                              clk,
    input  logic signed [31:0]                pos,
    input  logic        [31:0]                inv_len,
    output logic signed [shk_pkg::FRAC_W-1:0] frac
);

    logic signed [32:0] inv_s;
    logic signed [64:0] prod_next;
    logic        [63:0] prod_reg;

    // Q16.16 times Q8.24 gives 40 fraction bits; dropping 8 leaves 32.
    always_comb
    begin
        inv_s     = $signed({1'b0, inv_len});
        prod_next = pos * inv_s;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next[63:0];
    end

    assign frac = $signed(prod_reg[63:8]);

endmodule

// ===== hdl/shk_offdiag.sv =====
module shk_offdiag (
    input  logic                              clk,
    input  logic signed [shk_pkg::FRAC_W-1:0] frac,
    input  logic signed [31:0]                coef,
    output logic        [shk_pkg::TERM_W-1:0] term
);

    logic signed [23:0] frac_hi;
    logic signed [32:0] frac_lo;
    logic signed [55:0] hi_prod_next;
    logic signed [64:0] lo_prod_next;
    logic        [55:0] hi_prod_reg;
    logic        [31:0] lo_top_reg;
    logic        [shk_pkg::TERM_W-1:0] term_next;
    logic        [shk_pkg::TERM_W-1:0] term_reg;

    // The fraction is split at its binary point so that both products stay
    // near 32 by 32 bits; the low product only contributes its floored top half.
    always_comb
    begin
        frac_hi      = frac[55:32];
        frac_lo      = $signed({1'b0, frac[31:0]});
        hi_prod_next = frac_hi * coef;
        lo_prod_next = frac_lo * coef;
        term_next    = {hi_prod_reg[55], hi_prod_reg} + {{25{lo_top_reg[31]}}, lo_top_reg};
    end

    always_ff @(posedge clk)
    begin
        hi_prod_reg <= hi_prod_next;
        lo_top_reg  <= lo_prod_next[63:32];
        term_reg    <= term_next;
    end

    assign term = term_reg;

endmodule

// ===== hdl/shk_hcell.sv =====
module shk_hcell (
    input  logic            clk,
    input  shk_pkg::hcell_t state_in,
    output shk_pkg::hcell_t state_out
);

    logic [2:0]      digit;
    logic [2:0]      rdigit;
    logic [2:0]      rot_sum;
    logic [1:0]      rot_inc;
    shk_pkg::hcell_t state_next;
    shk_pkg::hcell_t state_reg;

    always_comb
    begin
        digit = state_in.code[shk_pkg::KEY_W-1 -: 3] ^ state_in.flip;

        case (state_in.rot)
            2'd1:    rdigit = {digit[0], digit[2:1]};
            2'd2:    rdigit = {digit[1:0], digit[2]};
            default: rdigit = digit;
        endcase

        // The lowest set bit of the rotated digit, limited to its two low bits, adds
        // its position plus one to the rotation, besides the step of one every digit adds.
        if (rdigit[0]) begin
            rot_inc = 2'd1;
        end
        else if (rdigit[1]) begin
            rot_inc = 2'd2;
        end
        else begin
            rot_inc = 2'd0;
        end
        rot_sum = 3'(state_in.rot) + 3'(rot_inc) + 3'd1;

        case (state_in.rot)
            2'd1:    state_next.flip = 3'b010;
            2'd2:    state_next.flip = 3'b100;
            default: state_next.flip = 3'b001;
        endcase

        state_next.rot  = (rot_sum >= 3'd3) ? 2'(rot_sum - 3'd3) : rot_sum[1:0];
        state_next.code = {state_in.code[shk_pkg::KEY_W-4:0], 3'b000};
        state_next.acc  = {state_in.acc[shk_pkg::KEY_W-4:0], rdigit};
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
    end

    assign state_out = state_reg;

endmodule

// ===== hdl/shk_checker.sv =====
`include "spatial_hilbert_key_core_macros.svh"

module shk_assertions (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [19:0] atom_index,
    input logic        done,
    input logic        pready
);

    localparam int LAT = shk_pkg::PIPE_DEPTH;

    logic start_in_range;

    assign start_in_range = start && !busy && (32'(atom_index) < shk_pkg::MAX_ATOMS);

    // The port never inserts wait states.
    `SHK_ASSERT_IMPLIES(a_pready_high, 1'b1, pready)

    // The pipeline never holds off a start.
    `SHK_ASSERT_IMPLIES(a_never_busy, 1'b1, !busy)

    // A key only appears a fixed latency after an accepted start.
    `SHK_ASSERT_IMPLIES(a_done_has_start, done, $past(start && !busy, LAT))

    // Every in-range atom yields exactly one key after the fixed latency.
    `SHK_ASSERT_IMPLIES(a_start_gives_done, start_in_range, ##LAT done)

endmodule

bind spatial_hilbert_key_core shk_assertions u_shk_assertions (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .atom_index (atom_index),
    .done       (done),
    .pready     (pready)
);

// ===== dv/shk_checker.sv =====
module shk_checker (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           start,
    input  logic                           busy,
    input  logic [31:0]                    pos_x,
    input  logic [31:0]                    pos_y,
    input  logic [31:0]                    pos_z,
    input  logic [19:0]                    atom_index,

    input  logic                           done,
    input  logic [29:0]                    hilbert_key,
    input  logic [19:0]                    atom_tag,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [shk_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    input  logic [31:0]                    prdata,
    input  logic                           pready,

    output logic                           keys_idle,
    output int                             keys_checked,
    output int                             fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [127:0] Q16_MAX = 128'sd2147483647;
    localparam logic signed [127:0] Q16_MIN = -128'sd2147483648;
    localparam logic [29:0] CURVE_XOR = 30'h0492_4924;
    localparam logic [31:0] ONE_Q8_24 = 32'h0100_0000;

    typedef struct packed {
        logic [29:0] key;
        logic [19:0] tag;
    } atom_key_t;

    atom_key_t   key_q[$];
    logic [31:0] inv_x;
    logic [31:0] inv_y;
    logic [31:0] inv_z;
    logic [31:0] shear_bx;
    logic [31:0] shear_cx;
    logic [31:0] shear_cy;
    int          checked_total = 0;
    int          err_total = 0;

    assign keys_checked = checked_total;
    assign fail_count   = err_total;

    // Unwrapped fraction with 32 fraction bits: floor(d * inv / 2^8).
    function automatic logic signed [63:0] box_fraction(input logic signed [31:0] d,
                                                        input logic [31:0] inv);
        logic signed [63:0] prod;
        prod = $signed({{32{d[31]}}, d}) * $signed({32'b0, inv});
        return prod >>> 8;
    endfunction

    // Exact floor(f * c / 2^32), the shear contribution in Q16.16.
    function automatic logic signed [127:0] shear_term(input logic signed [63:0] f,
                                                       input logic signed [31:0] c);
        logic signed [127:0] p;
        p = f;
        p = p * c;
        return p >>> 32;
    endfunction

    function automatic logic [31:0] clamp_q16(input logic signed [127:0] v);
        if (v > Q16_MAX) begin
            return 32'h7FFF_FFFF;
        end
        if (v < Q16_MIN) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Walks the ten octal digits from the top, tracking rotation and flip of the cube.
    function automatic logic [29:0] hilbert_index(input logic [9:0] cx, input logic [9:0] cy,
                                                  input logic [9:0] cz);
        logic [31:0] m;
        logic [29:0] acc;
        logic [2:0]  t;
        logic [5:0]  dbl;
        logic [2:0]  flip;
        int          rot;
        m = '0;
        for (int i = 0; i < 10; i++) begin
            m[3*i]   = cx[i];
            m[3*i+1] = cy[i];
            m[3*i+2] = cz[i];
        end
        m = m ^ (m >> 3);
        acc = '0;
        flip = '0;
        rot = 0;
        for (int p = 27; p >= 0; p -= 3) begin
            t = flip ^ m[p +: 3];
            dbl = {t, t} >> rot;
            t = dbl[2:0];
            acc = {acc[26:0], t};
            flip = 3'(1 << rot);
            if (t[0]) begin
                rot += 1;
            end else if (t[1]) begin
                rot += 2;
            end
            rot += 1;
            if (rot >= 3) begin
                rot -= 3;
            end
        end
        acc = acc ^ CURVE_XOR;
        for (int s = 1; s < 30; s *= 2) begin
            acc = acc ^ (acc >> s);
        end
        return acc;
    endfunction

    function automatic atom_key_t predict_key(input logic [31:0] px, input logic [31:0] py,
                                              input logic [31:0] pz, input logic [19:0] idx);
        logic signed [63:0]  fz;
        logic signed [63:0]  fy;
        logic signed [63:0]  fx;
        logic signed [127:0] dy;
        logic signed [127:0] dx;
        atom_key_t           r;
        fz = box_fraction(pz, inv_z);
        dy = $signed(py) - shear_term(fz, shear_cy);
        fy = box_fraction(clamp_q16(dy), inv_y);
        dx = $signed(px) - shear_term(fy, shear_bx) - shear_term(fz, shear_cx);
        fx = box_fraction(clamp_q16(dx), inv_x);
        r.key = hilbert_index(fx[31:22], fy[31:22], fz[31:22]);
        r.tag = idx;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        atom_key_t        want;
        shk_pkg::reg_idx_t ridx;
        logic [31:0]      held;
        logic             known;
        if (!rst_n) begin
            inv_x = ONE_Q8_24;
            inv_y = ONE_Q8_24;
            inv_z = ONE_Q8_24;
            shear_bx = '0;
            shear_cx = '0;
            shear_cy = '0;
            key_q.delete();
            keys_idle <= 1'b1;
        end else begin
            if (done) begin
                if (key_q.size() == 0) begin
                    $error("unexpected key transfer: hilbert_key %h atom_tag %h",
                           hilbert_key, atom_tag);
                    err_total++;
                end else begin
                    want = key_q.pop_front();
                    checked_total++;
                    if (hilbert_key !== want.key) begin
                        $error("hilbert_key mismatch (atom %0d): expected %h, actual %h",
                               want.tag, want.key, hilbert_key);
                        err_total++;
                    end
                    if (atom_tag !== want.tag) begin
                        $error("atom_tag mismatch: expected %h, actual %h", want.tag, atom_tag);
                        err_total++;
                    end
                end
            end

            if (start && !busy) begin
                key_q.push_back(predict_key(pos_x, pos_y, pos_z, atom_index));
            end

            if (psel && penable && pready) begin
                ridx = shk_pkg::reg_idx_t'(paddr[4:2]);
                known = 1'b1;
                held = '0;
                case (ridx)
                    shk_pkg::REG_INV_X_LEN: held = inv_x;
                    shk_pkg::REG_INV_Y_LEN: held = inv_y;
                    shk_pkg::REG_INV_Z_LEN: held = inv_z;
                    shk_pkg::REG_BOX_B_X:   held = shear_bx;
                    shk_pkg::REG_BOX_C_X:   held = shear_cx;
                    shk_pkg::REG_BOX_C_Y:   held = shear_cy;
                    default:                known = 1'b0;
                endcase
                if (pwrite) begin
                    case (ridx)
                        shk_pkg::REG_INV_X_LEN: inv_x = pwdata;
                        shk_pkg::REG_INV_Y_LEN: inv_y = pwdata;
                        shk_pkg::REG_INV_Z_LEN: inv_z = pwdata;
                        shk_pkg::REG_BOX_B_X:   shear_bx = pwdata;
                        shk_pkg::REG_BOX_C_X:   shear_cx = pwdata;
                        shk_pkg::REG_BOX_C_Y:   shear_cy = pwdata;
                        default:                ;
                    endcase
                end else if (known && prdata !== held) begin
                    $error("prdata mismatch at %h: expected %h, actual %h", paddr, held, prdata);
                    err_total++;
                end
            end

            keys_idle <= (key_q.size() == 0);
        end
    end

endmodule

// ===== dv/tb_spatial_hilbert_key_core.sv =====
module tb_spatial_hilbert_key_core;
    timeunit 1ns;
    timeprecision 1ps;

    // Register slots past the last defined one. Writes there must be ignored.
    localparam int REG_SPARE_LO = 6;
    localparam int REG_SPARE_HI = 7;
    localparam int RANDOM_PER_SETTING = 82;
    localparam logic [31:0] ONE_Q8_24 = 32'h0100_0000;
    localparam logic [31:0] ONE_Q16_16 = 32'h0001_0000;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic [31:0]                    pos_x = '0;
    logic [31:0]                    pos_y = '0;
    logic [31:0]                    pos_z = '0;
    logic [19:0]                    atom_index = '0;
    logic                           done;
    logic [29:0]                    hilbert_key;
    logic [19:0]                    atom_tag;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [shk_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [31:0]                    pwdata = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    logic                           keys_idle;
    int                             keys_checked;
    int                             fail_count;

    // Bookkeeping for the closing summary and for the idle pattern of the sender.
    int                             atoms_sent = 0;
    int                             box_settings = 0;
    int                             burst_left = 0;

    always #10 clk = ~clk;

    spatial_hilbert_key_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .atom_index  (atom_index),
        .done        (done),
        .hilbert_key (hilbert_key),
        .atom_tag    (atom_tag),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // The checker sees the same pins as the block. It predicts every key from the
    // register writes it has observed and compares each done transfer in order.
    shk_checker key_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .atom_index   (atom_index),
        .done         (done),
        .hilbert_key  (hilbert_key),
        .atom_tag     (atom_tag),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .keys_idle    (keys_idle),
        .keys_checked (keys_checked),
        .fail_count   (fail_count)
    );

    // One APB access: a setup phase, then access cycles until pready. The bus
    // is then left idle so that psel is never lowered and raised again in the
    // same time step by back-to-back accesses.
    task automatic apb_access(input bit is_write, input int idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= shk_pkg::APB_ADDR_W'(idx * 4);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Stops issuing atoms and waits until every predicted key has come back. The
    // first edge lets the checker account for a transfer accepted just before.
    task automatic drain_keys();
        start <= 1'b0;
        @(posedge clk);
        while (!keys_idle) @(posedge clk);
    endtask

    // Registers are only touched with the pipeline empty. Every register is read
    // back after the writes, so a dropped or misrouted write shows up at once.
    task automatic apply_box(input logic [31:0] ix, input logic [31:0] iy,
                             input logic [31:0] iz, input logic [31:0] bx,
                             input logic [31:0] cx, input logic [31:0] cy);
        drain_keys();
        apb_access(1'b1, shk_pkg::REG_INV_X_LEN, ix);
        apb_access(1'b1, shk_pkg::REG_INV_Y_LEN, iy);
        apb_access(1'b1, shk_pkg::REG_INV_Z_LEN, iz);
        apb_access(1'b1, shk_pkg::REG_BOX_B_X, bx);
        apb_access(1'b1, shk_pkg::REG_BOX_C_X, cx);
        apb_access(1'b1, shk_pkg::REG_BOX_C_Y, cy);
        for (int i = shk_pkg::REG_INV_X_LEN; i <= shk_pkg::REG_BOX_C_Y; i++) begin
            apb_access(1'b0, i, '0);
        end
        box_settings++;
    endtask

    // The sender idles for the gap that draw_gap returns before each atom, except
    // during bursts in which atoms follow one another on consecutive cycles.
    function automatic int draw_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst_left = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    // Holds start high with the atom until the block takes the transfer. start
    // is only lowered when a gap follows, so it is never toggled within a step.
    task automatic send_atom(input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz, input logic [19:0] idx);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        pos_x <= px;
        pos_y <= py;
        pos_z <= pz;
        atom_index <= idx;
        do @(posedge clk); while (busy);
        atoms_sent++;
    endtask

    // Positions mostly fall within a few box lengths of the origin, so that the
    // cell coordinates spread over the whole grid and the wrap is exercised on
    // both sides. The rest are full-range words, the signed extremes, 0 and -1.
    function automatic logic [31:0] pick_position(input int unsigned span);
        logic signed [63:0] v;
        int unsigned        sel;
        sel = $urandom_range(0, 9);
        if (sel < 2) begin
            return $urandom();
        end
        if (sel == 2) begin
            case ($urandom_range(0, 3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        v = $signed({32'b0, $urandom_range(0, 4 * span)}) - $signed({32'b0, 3 * (span / 2)});
        return v[31:0];
    endfunction

    task automatic random_atoms(input int count, input int unsigned span);
        for (int i = 0; i < count; i++) begin
            send_atom(pick_position(span), pick_position(span), pick_position(span),
                      20'($urandom_range(0, 20'hF_FFFF)));
        end
    endtask

    // A triclinic box with edge lengths of 8 to 200 units. The reciprocals are
    // 2^40 / the Q16.16 length, or 0 for y if zero_y; shears lie within half a length.
    task automatic realistic_box(input bit zero_y, output int unsigned span);
        logic [63:0] len_x;
        logic [63:0] len_y;
        logic [63:0] len_z;
        logic [63:0] inv_x;
        logic [63:0] inv_y;
        logic [63:0] inv_z;
        logic [31:0] b_x;
        logic [31:0] c_x;
        logic [31:0] c_y;
        len_x = $urandom_range(8 << 16, 200 << 16);
        len_y = $urandom_range(8 << 16, 200 << 16);
        len_z = $urandom_range(8 << 16, 200 << 16);
        inv_x = 64'h100_0000_0000 / len_x;
        inv_y = zero_y ? 64'd0 : 64'h100_0000_0000 / len_y;
        inv_z = 64'h100_0000_0000 / len_z;
        b_x = $urandom_range(0, len_y[31:0]) - len_y[31:0] / 2;
        c_x = $urandom_range(0, len_z[31:0]) - len_z[31:0] / 2;
        c_y = $urandom_range(0, len_z[31:0]) - len_z[31:0] / 2;
        apply_box(inv_x[31:0], inv_y[31:0], inv_z[31:0], b_x, c_x, c_y);
        span = 32'(len_x > len_z ? len_x : len_z);
    endtask

    initial begin
        int unsigned span;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values of all registers, read before anything is written.
        for (int i = shk_pkg::REG_INV_X_LEN; i <= shk_pkg::REG_BOX_C_Y; i++) begin
            apb_access(1'b0, i, '0);
        end

        // Unit box, no shear: the cell of each axis is bits 15:6 of its position.
        // Covers zero, the largest fraction, exact integers that wrap to zero,
        // negative values that wrap to the top cell, the signed extremes, and
        // the smallest and largest atom index.
        send_atom(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 20'h0_0000);
        send_atom(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 20'hF_FFFF);
        send_atom(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'h0_0001);
        send_atom(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 20'h8_0000);
        send_atom(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'h7_FFFF);
        send_atom(ONE_Q16_16, 32'h0000_8000, 32'h0000_C000, 20'h0_1234);
        send_atom(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 20'h5_5555);
        send_atom(32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC, 20'hA_AAAA);
        send_atom(32'h0000_0040, 32'h0000_003F, 32'h0000_FFC0, 20'h0_0040);

        // Largest reciprocals with the shears at opposite extremes: the
        // corrected y and x positions run out of range and saturate.
        apply_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_atom(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 20'h0_0002);
        send_atom(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 20'h0_0003);
        send_atom(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 20'h0_0004);
        send_atom(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 20'h0_0005);
        send_atom(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'h0_0006);

        // Zero reciprocals force every cell to zero whatever the position.
        // Writes to the spare slots go along and must change nothing.
        apply_box(32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        apb_access(1'b1, REG_SPARE_LO, 32'hDEAD_BEEF);
        apb_access(1'b1, REG_SPARE_HI, 32'h1234_5678);
        for (int i = shk_pkg::REG_INV_X_LEN; i <= shk_pkg::REG_BOX_C_Y; i++) begin
            apb_access(1'b0, i, '0);
        end
        send_atom(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 20'h0_0007);
        send_atom(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 20'h0_0008);
        send_atom(32'h0001_8000, 32'hFFFE_8000, 32'h0000_4000, 20'h0_0009);

        // Random atoms in a sequence of box settings.
        apply_box(ONE_Q8_24, ONE_Q8_24, ONE_Q8_24, 32'h0, 32'h0, 32'h0);
        random_atoms(RANDOM_PER_SETTING, 4 << 16);

        realistic_box(1'b0, span);
        random_atoms(RANDOM_PER_SETTING, span);

        realistic_box(1'b0, span);
        random_atoms(RANDOM_PER_SETTING, span);

        // A box with a zero y reciprocal: the y cell stays zero and the b shear adds nothing to x.
        realistic_box(1'b1, span);
        random_atoms(RANDOM_PER_SETTING, span);

        apply_box($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        random_atoms(RANDOM_PER_SETTING, 1 << 29);

        // Smallest nonzero reciprocals with the most negative shears.
        apply_box(32'h1, 32'h1, 32'h1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        random_atoms(RANDOM_PER_SETTING, 1 << 29);

        drain_keys();
        repeat (shk_pkg::PIPE_DEPTH + 8) @(posedge clk);

        $display("Sent %0d atoms over %0d box settings and checked %0d keys.",
                 atoms_sent, box_settings + 1, keys_checked);
        $display("Settings ranged over unit, triclinic, saturating and zero-reciprocal boxes.");
        if (fail_count == 0) begin
            $display("spatial_hilbert_key_core test passed");
        end else begin
            $display("spatial_hilbert_key_core test failed");
        end
        $finish;
    end

    // The run normally takes well under a millisecond; this catches a hang.
    initial begin
        #10_000_000;
        $display("spatial_hilbert_key_core test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/shk_pkg.sv
hdl/shk_scale.sv
hdl/shk_offdiag.sv
hdl/shk_hcell.sv
hdl/spatial_hilbert_key_core.sv
hdl/shk_checker.sv
dv/shk_checker.sv
dv/tb_spatial_hilbert_key_core.sv
